/* design/dap_pkg.sv */
// Shared types, constants and calendar functions for the date plus period block.
package dap_pkg;

   localparam int unsigned DAY_ADD_BITS_DEF = 16;
   localparam int unsigned MAX_YEAR_DEF     = 9999;

   localparam int unsigned YEAR_FIELD_W  = 14;
   localparam int unsigned MONTH_FIELD_W = 4;
   localparam int unsigned DAY_FIELD_W   = 5;
   localparam int unsigned ADD_YEAR_W    = 14;
   localparam int unsigned ADD_MONTH_W   = 12;

   // Holds a start month plus the largest month addition.
   localparam int unsigned MON_W = 13;
   localparam int unsigned REM_W = 9;

   localparam int unsigned MONTHS_PER_YEAR = 12;
   localparam int unsigned CYCLE_DAYS      = 146097;
   localparam int unsigned CYCLE_YEARS     = 400;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_REDUCE = 6'b000010,
      ST_NORM   = 6'b000100,
      ST_CYCLE  = 6'b001000,
      ST_DONE   = 6'b010000,
      ST_SAT    = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      PH_YEARS  = 2'd0,
      PH_MONTHS = 2'd1,
      PH_DAYS   = 2'd2
   } phase_type;

   // The argument is the year modulo 400.
   function automatic logic is_leap(input logic [REM_W-1:0] rem);
      logic century;
      century = (rem == REM_W'(100)) || (rem == REM_W'(200)) || (rem == REM_W'(300));
      return (rem[1:0] == 2'b00) && !century;
   endfunction

   function automatic logic [DAY_FIELD_W-1:0] days_in_month(input logic [MONTH_FIELD_W-1:0] month,
                                                           input logic leap);
      logic [DAY_FIELD_W-1:0] len;
      case (month) inside
         4'd2: begin
            len = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

endpackage

/* design/date_add_period.sv */
// Top level: adds a period of years, months and days to a Gregorian date.
// The sequencer reduces the start year plus added years modulo 400, then steps month carries
// and day rolls in a shared normalizing unit and takes whole 400-year cycles off the days.
// One word is in flight at a time, so a new word is taken in the cycle after the result
// word leaves. Synchronous reset returns the sequencer to idle with no result pending.
module date_add_period #(
   parameter int unsigned DAY_ADD_BITS = dap_pkg::DAY_ADD_BITS_DEF,
   parameter int unsigned MAX_YEAR     = dap_pkg::MAX_YEAR_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dap_pkg::YEAR_FIELD_W-1:0]    req_start_year,
   input  logic [dap_pkg::MONTH_FIELD_W-1:0]   req_start_month,
   input  logic [dap_pkg::DAY_FIELD_W-1:0]     req_start_day,
   input  logic [dap_pkg::ADD_YEAR_W-1:0]      req_add_years,
   input  logic [dap_pkg::ADD_MONTH_W-1:0]     req_add_months,
   input  logic [DAY_ADD_BITS-1:0]             req_add_days,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dap_pkg::YEAR_FIELD_W-1:0]    rsp_end_year,
   output logic [dap_pkg::MONTH_FIELD_W-1:0]   rsp_end_month,
   output logic [dap_pkg::DAY_FIELD_W-1:0]     rsp_end_day,
   output logic                                rsp_overflow
);

   localparam int unsigned YEAR_W = $clog2(MAX_YEAR + 32769);
   localparam int unsigned DAY_W  = DAY_ADD_BITS + 1;
   localparam int unsigned MON_W  = dap_pkg::MON_W;
   localparam int unsigned REM_W  = dap_pkg::REM_W;

   dap_pkg::state_type state_ff, state_in;
   dap_pkg::phase_type phase_ff, phase_in;

   logic [YEAR_W-1:0]                  year_ff, year_in;
   logic [YEAR_W-1:0]                  rem_ff, rem_in;
   logic [MON_W-1:0]                   month_ff, month_in;
   logic [DAY_W-1:0]                   day_ff, day_in;
   logic [dap_pkg::ADD_MONTH_W-1:0]    add_months_ff, add_months_in;
   logic [DAY_ADD_BITS-1:0]            add_days_ff, add_days_in;
   logic                               overflow_ff, overflow_in;

   logic                               accept;
   logic                               leap;
   logic [dap_pkg::DAY_FIELD_W-1:0]    month_len;
   logic                               year_over;
   logic [YEAR_W-1:0]                  start_year;
   logic [MON_W-1:0]                   start_month;
   logic [DAY_W-1:0]                   start_day;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != dap_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == dap_pkg::ST_DONE);

   assign rsp_end_year  = year_ff[dap_pkg::YEAR_FIELD_W-1:0];
   assign rsp_end_month = month_ff[dap_pkg::MONTH_FIELD_W-1:0];
   assign rsp_end_day   = day_ff[dap_pkg::DAY_FIELD_W-1:0];
   assign rsp_overflow  = overflow_ff;

   assign leap      = dap_pkg::is_leap(rem_ff[REM_W-1:0]);
   assign month_len = dap_pkg::days_in_month(month_ff[dap_pkg::MONTH_FIELD_W-1:0], leap);
   assign year_over = (year_ff > YEAR_W'(MAX_YEAR));

   assign start_year  = (req_start_year == '0) ? YEAR_W'(1) : YEAR_W'(req_start_year);
   assign start_month = (req_start_month == '0) ? MON_W'(1) : MON_W'(req_start_month);
   assign start_day   = (req_start_day == '0) ? DAY_W'(1) : DAY_W'(req_start_day);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      year_in       = year_ff;
      rem_in        = rem_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      add_months_in = add_months_ff;
      add_days_in   = add_days_ff;
      overflow_in   = overflow_ff;
      case (state_ff)
         dap_pkg::ST_IDLE: begin
            if (accept) begin
               year_in       = start_year + YEAR_W'(req_add_years);
               rem_in        = start_year + YEAR_W'(req_add_years);
               month_in      = start_month;
               day_in        = start_day;
               add_months_in = req_add_months;
               add_days_in   = req_add_days;
               overflow_in   = 1'b0;
               phase_in      = dap_pkg::PH_YEARS;
               state_in      = dap_pkg::ST_REDUCE;
            end
         end
         dap_pkg::ST_REDUCE: begin
            if (rem_ff >= YEAR_W'(dap_pkg::CYCLE_YEARS)) begin
               rem_in = rem_ff - YEAR_W'(dap_pkg::CYCLE_YEARS);
            end else begin
               state_in = dap_pkg::ST_NORM;
            end
         end
         dap_pkg::ST_NORM: begin
            if (year_over) begin
               state_in = dap_pkg::ST_SAT;
            end else if (month_ff > MON_W'(dap_pkg::MONTHS_PER_YEAR)) begin
               month_in = month_ff - MON_W'(dap_pkg::MONTHS_PER_YEAR);
               year_in  = year_ff + YEAR_W'(1);
               rem_in   = (rem_ff == YEAR_W'(dap_pkg::CYCLE_YEARS - 1)) ? '0
                          : rem_ff + YEAR_W'(1);
            end else if (day_ff > DAY_W'(month_len)) begin
               day_in   = day_ff - DAY_W'(month_len);
               month_in = month_ff + MON_W'(1);
            end else begin
               case (phase_ff)
                  dap_pkg::PH_YEARS: begin
                     month_in = month_ff + MON_W'(add_months_ff);
                     phase_in = dap_pkg::PH_MONTHS;
                  end
                  dap_pkg::PH_MONTHS: begin
                     day_in   = day_ff + DAY_W'(add_days_ff);
                     phase_in = dap_pkg::PH_DAYS;
                     state_in = dap_pkg::ST_CYCLE;
                  end
                  default: begin
                     state_in = dap_pkg::ST_DONE;
                  end
               endcase
            end
         end
         dap_pkg::ST_CYCLE: begin
            if (year_over) begin
               state_in = dap_pkg::ST_SAT;
            end else if (32'(day_ff) > dap_pkg::CYCLE_DAYS) begin
               day_in  = day_ff - DAY_W'(dap_pkg::CYCLE_DAYS);
               year_in = year_ff + YEAR_W'(dap_pkg::CYCLE_YEARS);
            end else begin
               state_in = dap_pkg::ST_NORM;
            end
         end
         dap_pkg::ST_SAT: begin
            year_in     = YEAR_W'(MAX_YEAR);
            month_in    = MON_W'(12);
            day_in      = DAY_W'(31);
            overflow_in = 1'b1;
            state_in    = dap_pkg::ST_DONE;
         end
         dap_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = dap_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dap_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dap_pkg::ST_IDLE;
         phase_ff <= dap_pkg::PH_YEARS;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      year_ff       <= year_in;
      rem_ff        <= rem_in;
      month_ff      <= month_in;
      day_ff        <= day_in;
      add_months_ff <= add_months_in;
      add_days_ff   <= add_days_in;
      overflow_ff   <= overflow_in;
   end

   // The year remainder stays a true residue while months and days are stepped.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == dap_pkg::ST_NORM) |-> (rem_ff < YEAR_W'(dap_pkg::CYCLE_YEARS)))
      else $error("year remainder out of range during normalization");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_end_month >= 4'd1) && (rsp_end_month <= 4'd12))
      else $error("result month out of range");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_end_month == 4'd12) && (rsp_end_day == 5'd31))
      else $error("saturated result is not the last day of the year");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (req_stall && !rsp_valid))
      else $error("result or new word taken right after accept");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result word repeated");

endmodule

/* sim/date_period_checker.sv */
// Watches both channels of the date plus period block, predicts each result word and compares.
`timescale 1ns / 100ps

module date_period_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [dap_pkg::YEAR_FIELD_W-1:0]    req_start_year,
   input  logic [dap_pkg::MONTH_FIELD_W-1:0]   req_start_month,
   input  logic [dap_pkg::DAY_FIELD_W-1:0]     req_start_day,
   input  logic [dap_pkg::ADD_YEAR_W-1:0]      req_add_years,
   input  logic [dap_pkg::ADD_MONTH_W-1:0]     req_add_months,
   input  logic [dap_pkg::DAY_ADD_BITS_DEF-1:0] req_add_days,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [dap_pkg::YEAR_FIELD_W-1:0]    rsp_end_year,
   input  logic [dap_pkg::MONTH_FIELD_W-1:0]   rsp_end_month,
   input  logic [dap_pkg::DAY_FIELD_W-1:0]     rsp_end_day,
   input  logic                                rsp_overflow,
   output int                                  mismatches,
   output int                                  pending
);

   localparam int YW = dap_pkg::YEAR_FIELD_W;
   localparam int MW = dap_pkg::MONTH_FIELD_W;
   localparam int DW = dap_pkg::DAY_FIELD_W;
   localparam int unsigned LAST_DAY = 31;

   typedef struct packed {
      logic [YW-1:0] year;
      logic [MW-1:0] month;
      logic [DW-1:0] day;
      logic          overflow;
   } date_word_type;

   date_word_type due_dates[$];

   function automatic bit leap_year(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
      int unsigned len;
      case (m)
         2: begin
            len = leap_year(y) ? 29 : 28;
         end
         4, 6, 9, 11: begin
            len = 30;
         end
         default: begin
            len = 31;
         end
      endcase
      return len;
   endfunction

   function automatic void normalize_date(inout int unsigned y, inout int unsigned m,
                                          inout int unsigned d);
      bit busy;
      busy = 1'b1;
      while (busy) begin
         if (m > dap_pkg::MONTHS_PER_YEAR) begin
            y += (m - 1) / dap_pkg::MONTHS_PER_YEAR;
            m = (m - 1) % dap_pkg::MONTHS_PER_YEAR + 1;
         end else if (d > month_length(y, m)) begin
            d -= month_length(y, m);
            m += 1;
         end else begin
            busy = 1'b0;
         end
      end
   endfunction

   function automatic date_word_type add_period(input int unsigned sy, input int unsigned sm,
                                                input int unsigned sd, input int unsigned py,
                                                input int unsigned pm, input int unsigned pd);
      int unsigned y;
      int unsigned m;
      int unsigned d;
      date_word_type w;
      y = (sy == 0) ? 1 : sy;
      m = (sm == 0) ? 1 : sm;
      d = (sd == 0) ? 1 : sd;
      y += py;
      normalize_date(y, m, d);
      m += pm;
      normalize_date(y, m, d);
      d += pd;
      while (d > dap_pkg::CYCLE_DAYS) begin
         d -= dap_pkg::CYCLE_DAYS;
         y += dap_pkg::CYCLE_YEARS;
      end
      normalize_date(y, m, d);
      w.overflow = 1'b0;
      if (y > dap_pkg::MAX_YEAR_DEF) begin
         y = dap_pkg::MAX_YEAR_DEF;
         m = dap_pkg::MONTHS_PER_YEAR;
         d = LAST_DAY;
         w.overflow = 1'b1;
      end
      w.year  = YW'(y);
      w.month = MW'(m);
      w.day   = DW'(d);
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      date_word_type seen;
      date_word_type want;
      seen = {rsp_end_year, rsp_end_month, rsp_end_day, rsp_overflow};
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_dates.size() == 0) begin
               report_mismatch($sformatf("unexpected word %0d-%0d-%0d overflow %0b",
                                         seen.year, seen.month, seen.day, seen.overflow));
            end else begin
               want = due_dates.pop_front();
               if (seen !== want) begin
                  report_mismatch($sformatf({"got %0d-%0d-%0d overflow %0b, ",
                                             "expected %0d-%0d-%0d overflow %0b"},
                                            seen.year, seen.month, seen.day, seen.overflow,
                                            want.year, want.month, want.day, want.overflow));
               end
            end
         end
         if (req_valid && !req_stall) begin
            due_dates.push_back(add_period(req_start_year, req_start_month, req_start_day,
                                           req_add_years, req_add_months, req_add_days));
         end
      end
      pending = due_dates.size();
   end

endmodule

/* sim/tb_top.sv */
// Testbench top: drives date words into the date plus period block and gives the verdict.
`timescale 1ns / 100ps

module tb_top;

   localparam int YW = dap_pkg::YEAR_FIELD_W;
   localparam int MW = dap_pkg::MONTH_FIELD_W;
   localparam int DW = dap_pkg::DAY_FIELD_W;
   localparam int AYW = dap_pkg::ADD_YEAR_W;
   localparam int AMW = dap_pkg::ADD_MONTH_W;
   localparam int ADW = dap_pkg::DAY_ADD_BITS_DEF;
   localparam int unsigned RANDOM_WORDS = 250;
   localparam int unsigned CALM_FROM = 220;

   logic           clock = 1'b0;
   logic           reset;
   logic           req_valid;
   logic           req_stall;
   logic [YW-1:0]  req_start_year;
   logic [MW-1:0]  req_start_month;
   logic [DW-1:0]  req_start_day;
   logic [AYW-1:0] req_add_years;
   logic [AMW-1:0] req_add_months;
   logic [ADW-1:0] req_add_days;
   logic           rsp_valid;
   logic           rsp_stall;
   logic [YW-1:0]  rsp_end_year;
   logic [MW-1:0]  rsp_end_month;
   logic [DW-1:0]  rsp_end_day;
   logic           rsp_overflow;
   logic           calm;
   int             mismatches;
   int             pending;

   date_add_period u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_year  (req_start_year),
      .req_start_month (req_start_month),
      .req_start_day   (req_start_day),
      .req_add_years   (req_add_years),
      .req_add_months  (req_add_months),
      .req_add_days    (req_add_days),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_end_year    (rsp_end_year),
      .rsp_end_month   (rsp_end_month),
      .rsp_end_day     (rsp_end_day),
      .rsp_overflow    (rsp_overflow)
   );

   date_period_checker u_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_year  (req_start_year),
      .req_start_month (req_start_month),
      .req_start_day   (req_start_day),
      .req_add_years   (req_add_years),
      .req_add_months  (req_add_months),
      .req_add_days    (req_add_days),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_end_year    (rsp_end_year),
      .rsp_end_month   (rsp_end_month),
      .rsp_end_day     (rsp_end_day),
      .rsp_overflow    (rsp_overflow),
      .mismatches      (mismatches),
      .pending         (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_word(input logic [YW-1:0] y, input logic [MW-1:0] m,
                            input logic [DW-1:0] d, input logic [AYW-1:0] py,
                            input logic [AMW-1:0] pm, input logic [ADW-1:0] pd);
      req_valid       <= 1'b1;
      req_start_year  <= y;
      req_start_month <= m;
      req_start_day   <= d;
      req_add_years   <= py;
      req_add_months  <= pm;
      req_add_days    <= pd;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      if (!calm && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold != 0) begin
            hold--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            hold = $urandom_range(0, 14);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [YW-1:0]  y;
      logic [MW-1:0]  m;
      logic [DW-1:0]  d;
      logic [AYW-1:0] py;
      logic [AMW-1:0] pm;
      logic [ADW-1:0] pd;
      int unsigned    pick;
      reset           = 1'b1;
      calm            = 1'b0;
      req_valid       = 1'b0;
      req_start_year  = '0;
      req_start_month = '0;
      req_start_day   = '0;
      req_add_years   = '0;
      req_add_months  = '0;
      req_add_days    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(14'd2000, 4'd1, 5'd1, 14'd0, 12'd0, 16'd0);
      sender_gap();
      send_word(14'd2024, 4'd2, 5'd29, 14'd1, 12'd0, 16'd0);
      sender_gap();
      send_word(14'd2000, 4'd2, 5'd29, 14'd100, 12'd0, 16'd0);
      sender_gap();
      send_word(14'd0, 4'd0, 5'd0, 14'd0, 12'd0, 16'd0);
      sender_gap();
      send_word(14'd2020, 4'd15, 5'd10, 14'd0, 12'd0, 16'd0);
      sender_gap();
      send_word(14'd2023, 4'd2, 5'd31, 14'd0, 12'd0, 16'd0);
      sender_gap();
      send_word(14'd1900, 4'd2, 5'd28, 14'd0, 12'd0, 16'd1);
      sender_gap();
      send_word(14'd2000, 4'd2, 5'd28, 14'd0, 12'd0, 16'd1);
      sender_gap();
      send_word(14'd2023, 4'd1, 5'd31, 14'd0, 12'd1, 16'd0);
      sender_gap();
      send_word(14'd2023, 4'd12, 5'd31, 14'd0, 12'd0, 16'd1);
      sender_gap();
      send_word(14'd9999, 4'd12, 5'd31, 14'd0, 12'd0, 16'd0);
      sender_gap();
      send_word(14'd9999, 4'd12, 5'd31, 14'd0, 12'd0, 16'd1);
      sender_gap();
      send_word(14'd12000, 4'd6, 5'd15, 14'd0, 12'd0, 16'd0);
      sender_gap();
      send_word(14'd16383, 4'd15, 5'd31, 14'd16383, 12'd4095, 16'd65535);
      sender_gap();
      send_word(14'd1, 4'd1, 5'd1, 14'd0, 12'd0, 16'd65535);
      sender_gap();
      send_word(14'd1, 4'd1, 5'd1, 14'd0, 12'd4095, 16'd0);
      sender_gap();
      send_word(14'd1, 4'd1, 5'd1, 14'd9998, 12'd0, 16'd0);
      sender_gap();
      send_word(14'd0, 4'd0, 5'd31, 14'd9999, 12'd11, 16'd0);
      sender_gap();
      send_word(14'd9000, 4'd3, 5'd1, 14'd999, 12'd9, 16'd400);
      sender_gap();
      send_word(14'd2096, 4'd2, 5'd29, 14'd4, 12'd0, 16'd0);
      sender_gap();

      for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
         if (n == CALM_FROM) begin
            calm = 1'b1;
         end
         if (n == 100 || n == 180) begin
            req_valid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            y  = YW'($urandom);
            m  = MW'($urandom);
            d  = DW'($urandom);
            py = AYW'($urandom);
            pm = AMW'($urandom);
            pd = ADW'($urandom);
         end else begin
            y  = YW'((pick == 1) ? $urandom_range(9900, 9999) : $urandom_range(1, 9999));
            m  = MW'($urandom_range(1, 12));
            d  = DW'((pick == 2) ? $urandom_range(25, 31) : $urandom_range(1, 28));
            py = AYW'((pick == 3) ? $urandom_range(0, 9999) : $urandom_range(0, 50));
            pm = AMW'((pick == 4) ? $urandom_range(0, 4095) : $urandom_range(0, 40));
            pd = ADW'((pick >= 7) ? $urandom_range(0, 65535) : $urandom_range(0, 400));
         end
         send_word(y, m, d, py, pm, pd);
         sender_gap();
      end

      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (2500) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
